// File: sv/assert_macros.svh
// Assertion macros for the key assigner RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// clocked property, switched off while reset is low
`define MKA_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("property failed");
// condition that must never be seen at a clock edge
`define MKA_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define MKA_ASSERT(lbl, clk, rst_n, prop)
`define MKA_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// File: sv/mka_pkg.sv
// Types and constants of the monophonic key assigner
`timescale 1ns / 1ps
`default_nettype none

package mka_pkg;

	localparam int ACTION_W = 2;
	localparam int NOTE_W   = 7;
	localparam int VEL_W    = 13;
	localparam int MODE_W   = 2;

	localparam int LEVEL_FRAC_BITS = 12;
	localparam logic [31:0] LEVEL_ONE = 32'd1 << LEVEL_FRAC_BITS;

	localparam logic [ACTION_W-1:0] ACT_NOTE_ON  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_NOTE_OFF = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_TICK     = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_CLEAR    = 2'd3;

	localparam logic [MODE_W-1:0] MODE_GATE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_TRIG = 2'd1;
	localparam logic [MODE_W-1:0] MODE_LFO  = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic note_on;
		logic note_off;
		logic clear;
		logic scan_start;
		logic scan_step;
		logic resolve;
		logic emit;
	} mka_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_last;
	} mka_sts_t;

endpackage

`default_nettype wire

// File: sv/mka_ifs.sv
// Channel interfaces: key events, tick results and mode register writes
`timescale 1ns / 1ps
`default_nettype none

interface mka_event_if;
	import mka_pkg::*;
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [NOTE_W-1:0]   note;
	logic [VEL_W-1:0]    velocity;
	modport source (output valid, action, note, velocity, input ready);
	modport sink   (input valid, action, note, velocity, output ready);
endinterface

interface mka_result_if;
	import mka_pkg::*;
	logic              valid;
	logic              ready;
	logic              gate;
	logic              note_valid;
	logic [NOTE_W-1:0] active_note;
	logic [VEL_W-1:0]  note_velocity;
	logic              retrigger;
	logic              clock_reset;
	modport source (output valid, gate, note_valid, active_note, note_velocity,
		retrigger, clock_reset, input ready);
	modport sink   (input valid, gate, note_valid, active_note, note_velocity,
		retrigger, clock_reset, output ready);
endinterface

interface mka_cfg_if;
	import mka_pkg::*;
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// File: sv/mka_ram.sv
// Generic single write port RAM with registered read
`timescale 1ns / 1ps
`default_nettype none

module mka_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                    clk,
	input  wire logic                                    wr_en,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                        wr_data,
	input  wire logic                                    rd_en,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                        rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: sv/mka_datapath.sv
// Key state, stamp and level memories, tick scan and result register
`timescale 1ns / 1ps
`default_nettype none

module mka_datapath #(
	parameter int NUM_KEYS    = 128,
	parameter int STAMP_WIDTH = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [mka_pkg::NOTE_W-1:0]   note,
	input  wire logic [mka_pkg::VEL_W-1:0]    velocity,
	input  wire logic                         cfg_valid,
	input  wire logic [mka_pkg::MODE_W-1:0]   cfg_data,
	input  wire mka_pkg::mka_cmd_t            cmd,
	output mka_pkg::mka_sts_t                 sts,
	output logic                              gate,
	output logic                              note_valid,
	output logic      [mka_pkg::NOTE_W-1:0]   active_note,
	output logic      [mka_pkg::VEL_W-1:0]    note_velocity,
	output logic                              retrigger,
	output logic                              clock_reset
);

	import mka_pkg::*;

	localparam int KEY_W = $clog2(NUM_KEYS);

	// architectural state
	logic [MODE_W-1:0]      mode_q;
	logic [NUM_KEYS-1:0]    held_q;
	logic [NUM_KEYS-1:0]    prev_q;
	logic [STAMP_WIDTH-1:0] next_stamp_q;
	logic                   lw_valid_q;
	logic [KEY_W-1:0]       lw_q;
	logic                   gate_was_on_q;
	logic                   new_press_q;

	// scan
	logic [NUM_KEYS-1:0]    sh_held_q;
	logic [NUM_KEYS-1:0]    sh_new_q;
	logic [KEY_W-1:0]       rd_idx_q;
	logic                   c_vld_s1;
	logic                   c_held_s1;
	logic                   c_new_s1;
	logic [KEY_W-1:0]       c_idx_s1;

	// running results of the scan
	logic                   any_q;
	logic                   any_new_q;
	logic                   lowh_found_q;
	logic [KEY_W-1:0]       lowh_q;
	logic                   lown_found_q;
	logic [KEY_W-1:0]       lown_q;
	logic                   max_found_q;
	logic [KEY_W-1:0]       max_idx_q;
	logic [STAMP_WIDTH-1:0] max_stamp_q;
	logic                   lw_held_q;

	// resolved tick
	logic                   r_any_q;
	logic                   r_found_q;
	logic [KEY_W-1:0]       r_win_q;
	logic                   r_retrig_q;
	logic                   r_clk_q;

	logic                   note_ok;
	logic [KEY_W-1:0]       key_idx;
	logic                   fresh_press;
	logic [VEL_W-1:0]       vel_sat;
	logic [STAMP_WIDTH-1:0] stamp_rd;
	logic [VEL_W-1:0]       level_rd;
	logic                   win_found;
	logic [KEY_W-1:0]       win_idx;
	logic                   mode_trig;
	logic                   mode_lfo;
	logic                   gate_edge;
	logic                   retrig_c;

	assign note_ok     = (32'(note) < 32'(NUM_KEYS));
	assign key_idx     = note[KEY_W-1:0];
	assign fresh_press = cmd.note_on && note_ok && !held_q[key_idx];
	assign vel_sat     = (32'(velocity) > LEVEL_ONE) ? LEVEL_ONE[VEL_W-1:0] : velocity;

	assign sts.scan_last = (rd_idx_q == KEY_W'(NUM_KEYS - 1));

	mka_ram #(
		.WIDTH(STAMP_WIDTH),
		.DEPTH(NUM_KEYS)
	) u_stamp_ram (
		.clk     (clk),
		.wr_en   (fresh_press),
		.wr_addr (key_idx),
		.wr_data (next_stamp_q),
		.rd_en   (cmd.scan_step),
		.rd_addr (rd_idx_q),
		.rd_data (stamp_rd)
	);

	mka_ram #(
		.WIDTH(VEL_W),
		.DEPTH(NUM_KEYS)
	) u_level_ram (
		.clk     (clk),
		.wr_en   (cmd.note_on && note_ok),
		.wr_addr (key_idx),
		.wr_data (vel_sat),
		.rd_en   (cmd.resolve),
		.rd_addr (win_idx),
		.rd_data (level_rd)
	);

	assign mode_trig = (mode_q == MODE_TRIG);
	assign mode_lfo  = (mode_q == MODE_LFO);

	// winner choice from the finished scan
	always_comb begin
		win_found = lowh_found_q;
		win_idx   = lowh_q;
		if (mode_trig) begin
			if (any_new_q) begin
				win_found = lown_found_q;
				win_idx   = lown_q;
			end else if (lw_valid_q && lw_held_q) begin
				win_found = 1'b1;
				win_idx   = lw_q;
			end else begin
				win_found = max_found_q;
				win_idx   = max_idx_q;
			end
		end
	end

	assign gate_edge = any_q && !gate_was_on_q;
	assign retrig_c  = mode_trig ? (gate_edge || (any_q && any_new_q)) :
		(mode_lfo ? 1'b0 : gate_edge);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_GATE;
			held_q        <= '0;
			prev_q        <= '0;
			next_stamp_q  <= STAMP_WIDTH'(1);
			lw_valid_q    <= 1'b0;
			lw_q          <= '0;
			gate_was_on_q <= 1'b0;
			new_press_q   <= 1'b0;
			c_vld_s1      <= 1'b0;
		end else begin
			c_vld_s1 <= cmd.scan_step;
			if (cfg_valid) begin
				mode_q <= cfg_data;
			end
			if (cmd.clear) begin
				held_q        <= '0;
				prev_q        <= '0;
				next_stamp_q  <= STAMP_WIDTH'(1);
				lw_valid_q    <= 1'b0;
				lw_q          <= '0;
				gate_was_on_q <= 1'b0;
				new_press_q   <= 1'b0;
			end
			if (cmd.note_on && note_ok) begin
				held_q[key_idx] <= 1'b1;
				new_press_q     <= 1'b1;
			end
			if (fresh_press) begin
				next_stamp_q <= next_stamp_q + STAMP_WIDTH'(1);
			end
			if (cmd.note_off && note_ok) begin
				held_q[key_idx] <= 1'b0;
			end
			if (cmd.emit) begin
				prev_q        <= held_q;
				lw_valid_q    <= r_found_q;
				lw_q          <= r_found_q ? r_win_q : '0;
				gate_was_on_q <= r_any_q;
				new_press_q   <= 1'b0;
			end
		end
	end

	// scan and result payload
	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			sh_held_q    <= held_q;
			sh_new_q     <= held_q & ~prev_q;
			rd_idx_q     <= '0;
			any_q        <= 1'b0;
			any_new_q    <= 1'b0;
			lowh_found_q <= 1'b0;
			lowh_q       <= '0;
			lown_found_q <= 1'b0;
			lown_q       <= '0;
			max_found_q  <= 1'b0;
			max_idx_q    <= '0;
			max_stamp_q  <= '0;
			lw_held_q    <= 1'b0;
		end else begin
			if (cmd.scan_step) begin
				c_held_s1 <= sh_held_q[0];
				c_new_s1  <= sh_new_q[0];
				c_idx_s1  <= rd_idx_q;
				sh_held_q <= sh_held_q >> 1;
				sh_new_q  <= sh_new_q >> 1;
				rd_idx_q  <= rd_idx_q + KEY_W'(1);
			end
			// stamp of key c_idx_s1 is on the RAM output now
			if (c_vld_s1) begin
				any_q     <= any_q | c_held_s1;
				any_new_q <= any_new_q | c_new_s1;
				if (c_held_s1 && !lowh_found_q) begin
					lowh_found_q <= 1'b1;
					lowh_q       <= c_idx_s1;
				end
				if (c_new_s1 && !lown_found_q) begin
					lown_found_q <= 1'b1;
					lown_q       <= c_idx_s1;
				end
				// ties go to the higher key
				if (c_held_s1 && stamp_rd >= max_stamp_q) begin
					max_found_q <= 1'b1;
					max_idx_q   <= c_idx_s1;
					max_stamp_q <= stamp_rd;
				end
				if (c_held_s1 && c_idx_s1 == lw_q) begin
					lw_held_q <= 1'b1;
				end
			end
		end
		if (cmd.resolve) begin
			r_any_q    <= any_q;
			r_found_q  <= win_found;
			r_win_q    <= win_idx;
			r_retrig_q <= retrig_c;
			r_clk_q    <= mode_lfo && new_press_q && any_q;
		end
		if (cmd.emit) begin
			gate          <= r_any_q;
			note_valid    <= r_found_q;
			active_note   <= r_found_q ? NOTE_W'(r_win_q) : '0;
			note_velocity <= r_found_q ? level_rd : LEVEL_ONE[VEL_W-1:0];
			retrigger     <= r_retrig_q;
			clock_reset   <= r_clk_q;
		end
	end

endmodule

`default_nettype wire

// File: sv/mka_ctrl.sv
// Controller: request decode, tick sequencing and result handshake
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module mka_ctrl (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           ev_valid,
	input  wire logic [mka_pkg::ACTION_W-1:0]   ev_action,
	output logic                                ev_ready,
	output logic                                res_valid,
	input  wire logic                           res_ready,
	output mka_pkg::mka_cmd_t                   cmd,
	input  wire mka_pkg::mka_sts_t              sts
);

	import mka_pkg::*;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_SCAN    = 3'd1;
	localparam logic [2:0] ST_FLUSH   = 3'd2;
	localparam logic [2:0] ST_RESOLVE = 3'd3;
	localparam logic [2:0] ST_EMIT    = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       accept;
	logic       res_valid_q;

	assign ev_ready  = (state_q == ST_IDLE);
	assign accept    = ev_valid && ev_ready;
	assign res_valid = res_valid_q;

	assign cmd.note_on    = accept && (ev_action == ACT_NOTE_ON);
	assign cmd.note_off   = accept && (ev_action == ACT_NOTE_OFF);
	assign cmd.scan_start = accept && (ev_action == ACT_TICK);
	assign cmd.clear      = accept && (ev_action == ACT_CLEAR);
	assign cmd.scan_step  = (state_q == ST_SCAN);
	assign cmd.resolve    = (state_q == ST_RESOLVE);
	// the result register may be refilled in the cycle it is taken
	assign cmd.emit       = (state_q == ST_EMIT) && (!res_valid_q || res_ready);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.scan_start) begin
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.scan_last) begin
					state_nxt = ST_FLUSH;
				end
			end
			ST_FLUSH:   state_nxt = ST_RESOLVE;
			ST_RESOLVE: state_nxt = ST_EMIT;
			ST_EMIT: begin
				if (cmd.emit) begin
					state_nxt = ST_IDLE;
				end
			end
			default:    state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	`MKA_ASSERT(a_tick_blocks_requests, clk, arst_n, cmd.scan_start |=> (state_q == ST_SCAN && !ev_ready))
	`MKA_ASSERT(a_resolve_after_flush, clk, arst_n, (cmd.scan_step && sts.scan_last) |=> ##1 cmd.resolve)
	`MKA_ASSERT(a_emit_fills_result, clk, arst_n, cmd.emit |=> (res_valid && state_q == ST_IDLE))
	`MKA_NEVER(a_scan_overrun, clk, arst_n, cmd.scan_step && $past(cmd.scan_step && sts.scan_last))

endmodule

`default_nettype wire

// File: sv/mono_key_assigner_unit.sv
// Top level of the monophonic key assigner
//
// channel  dir  handshake      carries
// events   in   valid / ready  action, note, velocity
// result   out  valid / ready  gate, note_valid, active_note, note_velocity,
//                              retrigger, clock_reset
// cfg      in   valid / ready  priority mode (always ready)
//
// A tick reads the press stamp memory one key per cycle on its single read port,
// then reads the winner's level. Reset clears key state; the memories need no
// clearing pass since only the entries of held keys are ever used. The finished
// result sits in an output register, so the next request is taken while it waits;
// a further tick holds before its emit cycle.
`timescale 1ns / 1ps
`default_nettype none

module mono_key_assigner_unit #(
	parameter int NUM_KEYS    = 128,
	parameter int STAMP_WIDTH = 32
) (
	input wire logic   clk,
	input wire logic   arst_n,
	mka_event_if.sink  events,
	mka_result_if.source result,
	mka_cfg_if.sink    cfg
);

	import mka_pkg::*;

	mka_cmd_t cmd;
	mka_sts_t sts;

	assign cfg.ready = 1'b1;

	mka_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.ev_valid  (events.valid),
		.ev_action (events.action),
		.ev_ready  (events.ready),
		.res_valid (result.valid),
		.res_ready (result.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	mka_datapath #(
		.NUM_KEYS    (NUM_KEYS),
		.STAMP_WIDTH (STAMP_WIDTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.note          (events.note),
		.velocity      (events.velocity),
		.cfg_valid     (cfg.valid),
		.cfg_data      (cfg.data),
		.cmd           (cmd),
		.sts           (sts),
		.gate          (result.gate),
		.note_valid    (result.note_valid),
		.active_note   (result.active_note),
		.note_velocity (result.note_velocity),
		.retrigger     (result.retrigger),
		.clock_reset   (result.clock_reset)
	);

endmodule

`default_nettype wire
